/* rtl/core/quaternion_to_rotation_matrix_defines.svh */
// assertion macros for the quaternion to rotation matrix block
`ifndef QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH
// implication checked on every clock edge outside reset
`define Q2R_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define Q2R_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/core/q2r_pkg.sv */
// package with shared types and constants for the quaternion to rotation matrix block
package q2r_pkg;
    localparam int unsigned EPS_WIDTH = 16;
    localparam logic [EPS_WIDTH-1:0] EPS_RESET = 16'd10737;
    localparam int unsigned NUM_ENTRIES = 9;
    localparam int unsigned NUM_OFFDIAG = 6;
    localparam int unsigned NUM_DIAG = 3;
endpackage

/* rtl/core/q2r_front.sv */
// front stage: products, norm and degenerate classification of one item
module q2r_front #(
    parameter int unsigned CW = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic signed [CW-1:0]       qw,
    input  logic signed [CW-1:0]       qx,
    input  logic signed [CW-1:0]       qy,
    input  logic signed [CW-1:0]       qz,
    input  logic [q2r_pkg::EPS_WIDTH-1:0] norm_epsilon,
    output logic                       out_valid,
    output logic [2*CW+1:0]            norm,
    output logic signed [2*CW+1:0]     num [q2r_pkg::NUM_ENTRIES],
    output logic                       degen
);
    import q2r_pkg::*;
    localparam int unsigned PW = 2*CW;
    localparam int unsigned NW = 2*CW+2;

    logic signed [PW-1:0] xx_reg, yy_reg, zz_reg, ww_reg, xy_reg, xz_reg, yz_reg;
    logic signed [PW-1:0] wx_reg, wy_reg, wz_reg;
    logic v1_reg, v2_reg;
    logic [NW-1:0] norm_reg;
    logic signed [NW-1:0] num_reg [NUM_ENTRIES];
    logic degen_reg;
    logic [NW-1:0] norm_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        xx_reg <= qx * qx;
        yy_reg <= qy * qy;
        zz_reg <= qz * qz;
        ww_reg <= qw * qw;
        xy_reg <= qx * qy;
        xz_reg <= qx * qz;
        yz_reg <= qy * qz;
        wx_reg <= qw * qx;
        wy_reg <= qw * qy;
        wz_reg <= qw * qz;
    end

    assign norm_next = NW'($unsigned(ww_reg)) + NW'($unsigned(xx_reg))
                     + NW'($unsigned(yy_reg)) + NW'($unsigned(zz_reg));

    always_ff @(posedge clk)
    begin
        norm_reg   <= norm_next;
        degen_reg  <= (norm_next == '0) || (norm_next < NW'(norm_epsilon));
        num_reg[0] <= NW'(yy_reg) + NW'(zz_reg);
        num_reg[1] <= NW'(xy_reg) + NW'(wz_reg);
        num_reg[2] <= NW'(xz_reg) - NW'(wy_reg);
        num_reg[3] <= NW'(xy_reg) - NW'(wz_reg);
        num_reg[4] <= NW'(xx_reg) + NW'(zz_reg);
        num_reg[5] <= NW'(yz_reg) + NW'(wx_reg);
        num_reg[6] <= NW'(xz_reg) + NW'(wy_reg);
        num_reg[7] <= NW'(yz_reg) - NW'(wx_reg);
        num_reg[8] <= NW'(xx_reg) + NW'(yy_reg);
    end

    assign out_valid = v2_reg;
    assign norm      = norm_reg;
    assign num       = num_reg;
    assign degen     = degen_reg;
endmodule

/* rtl/core/q2r_fifo.sv */
// short queue between front and back stages
module q2r_fifo #(
    parameter int unsigned W = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         not_empty
);
    localparam int unsigned AW = $clog2(DEPTH);
    logic [W-1:0] mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd_en)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    assign rd_data   = mem[rp_reg];
    assign not_empty = (cnt_reg != '0);
endmodule

/* rtl/core/q2r_divider.sv */
// pipelined restoring divider: round(p * 2^(CW-1) / n), or 2^(CW-2) minus that if diag, saturated
module q2r_divider #(
    parameter int unsigned CW = 16
) (
    input  logic                 clk,
    input  logic signed [2*CW+1:0] p,
    input  logic [2*CW+1:0]      n,
    input  logic                 diag,
    output logic signed [CW-1:0] r
);
    localparam int unsigned NW = 2*CW+2;
    localparam int unsigned ST = CW;
    localparam int unsigned QW = CW+1;

    logic [NW:0]   rem_reg [ST+1];
    logic [QW-1:0] q_reg   [ST+1];
    logic [NW-1:0] n_reg   [ST+1];
    logic          neg_reg [ST+1];
    logic          dg_reg  [ST+1];
    logic [NW-1:0] mag;
    logic [NW:0]   r0;
    logic [QW:0]   qr;
    logic signed [QW+1:0] sq, res;
    logic signed [QW+1:0] hi, lo;

    assign mag = p[NW-1] ? NW'(-p) : NW'(p);

    always_comb
    begin
        r0 = {1'b0, mag};
        if (r0 >= {1'b0, n})
        begin
            r0 = r0 - {1'b0, n};
            if (r0 >= {1'b0, n})
            begin
                r0 = {1'b0, n} - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= r0;
        q_reg[0]   <= QW'({1'b0, mag} >= {1'b0, n});
        n_reg[0]   <= n;
        neg_reg[0] <= p[NW-1];
        dg_reg[0]  <= diag;
    end

    for (genvar i = 0; i < ST; i++)
    begin : g_st
        logic [NW:0] sh;
        if (i < ST-1)
        begin : g_div
            assign sh = {rem_reg[i][NW-1:0], 1'b0};
            always_ff @(posedge clk)
            begin
                if (sh >= {1'b0, n_reg[i]})
                begin
                    rem_reg[i+1] <= sh - {1'b0, n_reg[i]};
                    q_reg[i+1]   <= {q_reg[i][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= sh;
                    q_reg[i+1]   <= {q_reg[i][QW-2:0], 1'b0};
                end
            end
        end
        else
        begin : g_rnd
            assign sh = {rem_reg[i][NW-1:0], 1'b0};
            always_ff @(posedge clk)
            begin
                rem_reg[i+1] <= '0;
                q_reg[i+1]   <= q_reg[i] + QW'(sh >= {1'b0, n_reg[i]});
            end
        end
        always_ff @(posedge clk)
        begin
            n_reg[i+1]   <= n_reg[i];
            neg_reg[i+1] <= neg_reg[i];
            dg_reg[i+1]  <= dg_reg[i];
        end
    end

    assign qr  = {1'b0, q_reg[ST]};
    assign sq  = neg_reg[ST] ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
    assign res = dg_reg[ST] ? ($signed((QW+2)'(1) <<< (CW-2)) - sq) : sq;
    assign hi  = $signed(((QW+2)'(1) <<< (CW-1)) - 1'b1);
    assign lo  = ~hi;
    assign r   = (res > hi) ? CW'(hi) : ((res < lo) ? CW'(lo) : CW'(res));
endmodule

/* rtl/core/q2r_back.sv */
// back stage: nine dividers, identity substitution and result register
module q2r_back #(
    parameter int unsigned CW = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [2*CW+1:0]        norm,
    input  logic signed [2*CW+1:0] num [q2r_pkg::NUM_ENTRIES],
    input  logic                   degen,
    output logic                   done,
    output logic signed [CW-1:0]   ent [q2r_pkg::NUM_ENTRIES],
    output logic                   degenerate
);
    import q2r_pkg::*;
    localparam int unsigned LAT = CW + 1;
    localparam int unsigned NW = 2*CW+2;

    logic [LAT-1:0] v_pipe_reg, d_pipe_reg;
    logic signed [CW-1:0] q [NUM_ENTRIES];
    logic signed [CW-1:0] ent_reg [NUM_ENTRIES];
    logic done_reg, degen_reg;
    logic [NW-1:0] nsafe;

    assign nsafe = degen ? NW'(1) : norm;

    for (genvar k = 0; k < NUM_ENTRIES; k++)
    begin : g_div
        q2r_divider #(.CW(CW)) u_div (
            .clk (clk),
            .p   (degen ? '0 : num[k]),
            .n   (nsafe),
            .diag(k == 0 || k == 4 || k == 8),
            .r   (q[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_pipe_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            v_pipe_reg <= {v_pipe_reg[LAT-2:0], in_valid};
            done_reg   <= v_pipe_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        d_pipe_reg <= {d_pipe_reg[LAT-2:0], degen};
        ent_reg    <= q;
        degen_reg  <= d_pipe_reg[LAT-1];
    end

    assign done       = done_reg;
    assign ent        = ent_reg;
    assign degenerate = degen_reg;
endmodule

/* rtl/core/quaternion_to_rotation_matrix.sv */
// Quaternion to 3x3 rotation matrix, top level.
// Usage:
//   An item (qw, qx, qy, qz, signed Q1.15) is taken at a clock edge with
//   start high and busy low. busy stays low, so an item may enter every cycle.
//   The result r00..r22 (signed Q2.14, saturated) and degenerate appear on
//   the result ports for one cycle with done high; the receiver cannot stall.
//   The path runs through the product and norm registers of the front part,
//   the queue, COMPONENT_WIDTH + 1 stages of the pipelined dividers and one
//   output register. Throughput is one item per cycle, set by the fully
//   pipelined dividers; the queue between front and back never fills.
//   norm_epsilon is written with cfg_we/cfg_data while the block is idle;
//   the user must keep to this, as the block does not enforce it.
//   Reset clears all control state and loads norm_epsilon with 10737.
//   Below that squared norm the identity is given and degenerate is set.
module quaternion_to_rotation_matrix #(
    parameter int unsigned COMPONENT_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COMPONENT_WIDTH-1:0]   qw,
    input  logic signed [COMPONENT_WIDTH-1:0]   qx,
    input  logic signed [COMPONENT_WIDTH-1:0]   qy,
    input  logic signed [COMPONENT_WIDTH-1:0]   qz,
    input  logic                                cfg_we,
    input  logic [q2r_pkg::EPS_WIDTH-1:0]       cfg_data,
    output logic                                done,
    output logic signed [COMPONENT_WIDTH-1:0]   r00,
    output logic signed [COMPONENT_WIDTH-1:0]   r01,
    output logic signed [COMPONENT_WIDTH-1:0]   r02,
    output logic signed [COMPONENT_WIDTH-1:0]   r10,
    output logic signed [COMPONENT_WIDTH-1:0]   r11,
    output logic signed [COMPONENT_WIDTH-1:0]   r12,
    output logic signed [COMPONENT_WIDTH-1:0]   r20,
    output logic signed [COMPONENT_WIDTH-1:0]   r21,
    output logic signed [COMPONENT_WIDTH-1:0]   r22,
    output logic                                degenerate
);
    import q2r_pkg::*;
    `include "quaternion_to_rotation_matrix_defines.svh"
    localparam int unsigned CW = COMPONENT_WIDTH;
    localparam int unsigned NW = 2*CW+2;
    localparam int unsigned QWID = NW*(NUM_ENTRIES+1) + 1;

    logic [EPS_WIDTH-1:0] eps_reg;
    logic f_valid, f_degen, q_ne;
    logic [NW-1:0] f_norm, b_norm;
    logic signed [NW-1:0] f_num [NUM_ENTRIES];
    logic signed [NW-1:0] b_num [NUM_ENTRIES];
    logic signed [CW-1:0] ent [NUM_ENTRIES];
    logic [QWID-1:0] q_in, q_out;
    logic b_degen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (cfg_we)
        begin
            eps_reg <= cfg_data;
        end
    end

    assign busy = 1'b0;

    q2r_front #(.CW(CW)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy),
        .qw(qw), .qx(qx), .qy(qy), .qz(qz), .norm_epsilon(eps_reg),
        .out_valid(f_valid), .norm(f_norm), .num(f_num), .degen(f_degen)
    );

    always_comb
    begin
        q_in = '0;
        q_in[NW-1:0] = f_norm;
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            q_in[NW*(k+1) +: NW] = f_num[k];
        end
        q_in[QWID-1] = f_degen;
    end

    q2r_fifo #(.W(QWID), .DEPTH(2)) u_fifo (
        .clk(clk), .rst_n(rst_n), .wr_en(f_valid), .wr_data(q_in),
        .rd_en(q_ne), .rd_data(q_out), .not_empty(q_ne)
    );

    always_comb
    begin
        b_norm = q_out[NW-1:0];
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            b_num[k] = q_out[NW*(k+1) +: NW];
        end
        b_degen = q_out[QWID-1];
    end

    q2r_back #(.CW(CW)) u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(q_ne), .norm(b_norm), .num(b_num),
        .degen(b_degen), .done(done), .ent(ent), .degenerate(degenerate)
    );

    assign r00 = ent[0];
    assign r01 = ent[1];
    assign r02 = ent[2];
    assign r10 = ent[3];
    assign r11 = ent[4];
    assign r12 = ent[5];
    assign r20 = ent[6];
    assign r21 = ent[7];
    assign r22 = ent[8];

    `Q2R_ASSERT_IMP(a_degen_identity, done && degenerate,
        r01 == '0 && r02 == '0 && r10 == '0 && r21 == '0, "degenerate result not identity")
    `Q2R_ASSERT_IMP(a_degen_diag, done && degenerate,
        r00 == r11 && r11 == r22, "degenerate diagonal differs")
    `Q2R_ASSERT_NEXT(a_cfg_write, cfg_we, eps_reg == $past(cfg_data), "epsilon not written")
endmodule

/* tb/sv/q2r_checker.sv */
// checker that predicts and compares rotation matrices from observed quaternion items
`timescale 1ns / 1ps
module q2r_checker #(
    parameter int unsigned CW = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic signed [CW-1:0]           qw,
    input  logic signed [CW-1:0]           qx,
    input  logic signed [CW-1:0]           qy,
    input  logic signed [CW-1:0]           qz,
    input  logic                           cfg_we,
    input  logic [q2r_pkg::EPS_WIDTH-1:0]  cfg_data,
    input  logic                           done,
    input  logic signed [CW-1:0]           r00,
    input  logic signed [CW-1:0]           r01,
    input  logic signed [CW-1:0]           r02,
    input  logic signed [CW-1:0]           r10,
    input  logic signed [CW-1:0]           r11,
    input  logic signed [CW-1:0]           r12,
    input  logic signed [CW-1:0]           r20,
    input  logic signed [CW-1:0]           r21,
    input  logic signed [CW-1:0]           r22,
    input  logic                           degenerate,
    output int                             errors,
    output int                             pending,
    output int                             matrices_seen,
    output int                             degenerate_seen
);
    import q2r_pkg::*;

    typedef struct packed {
        logic [NUM_ENTRIES-1:0][CW-1:0] m;
        logic                           degen;
    } rot_matrix_t;

    rot_matrix_t             matrix_q[$];
    logic [EPS_WIDTH-1:0]    eps_reg;

    // rounded p * 2^(CW-1) / n, ties away from zero
    function automatic longint scaled_div(longint p, longint n);
        longint a;
        longint q;
        longint r;
        a = (p < 0) ? -p : p;
        q = (a << (CW - 1)) / n;
        r = (a << (CW - 1)) % n;
        if ((r << 1) >= n)
            q++;
        return (p < 0) ? -q : q;
    endfunction

    function automatic logic [CW-1:0] sat_entry(longint v);
        longint hi;
        hi = (longint'(1) << (CW - 1)) - 1;
        if (v > hi)
            v = hi;
        if (v < -hi - 1)
            v = -hi - 1;
        return v[CW-1:0];
    endfunction

    function automatic rot_matrix_t quat_to_matrix(longint w, longint x, longint y, longint z,
                                                   longint eps);
        rot_matrix_t res;
        longint one;
        longint n;
        longint e[NUM_ENTRIES];
        one = longint'(1) << (CW - 2);
        n = w*w + x*x + y*y + z*z;
        if (n == 0 || n < eps) begin
            foreach (e[k])
                e[k] = 0;
            e[0] = one;
            e[4] = one;
            e[8] = one;
            res.degen = 1'b1;
        end
        else begin
            e[0] = one - scaled_div(y*y + z*z, n);
            e[1] = scaled_div(x*y + w*z, n);
            e[2] = scaled_div(x*z - w*y, n);
            e[3] = scaled_div(x*y - w*z, n);
            e[4] = one - scaled_div(x*x + z*z, n);
            e[5] = scaled_div(y*z + w*x, n);
            e[6] = scaled_div(x*z + w*y, n);
            e[7] = scaled_div(y*z - w*x, n);
            e[8] = one - scaled_div(x*x + y*y, n);
            res.degen = 1'b0;
        end
        foreach (e[k])
            res.m[k] = sat_entry(e[k]);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        rot_matrix_t exp_m;
        logic [NUM_ENTRIES-1:0][CW-1:0] got;
        if (!rst_n) begin
            eps_reg = EPS_RESET;
            matrix_q.delete();
            errors = 0;
            pending = 0;
            matrices_seen = 0;
            degenerate_seen = 0;
        end
        else begin
            if (done) begin
                got = {r22, r21, r20, r12, r11, r10, r02, r01, r00};
                if (matrix_q.size() == 0) begin
                    $display("%0t: unexpected matrix, actual degenerate=%0b", $time, degenerate);
                    errors++;
                end
                else begin
                    exp_m = matrix_q.pop_front();
                    matrices_seen++;
                    if (degenerate)
                        degenerate_seen++;
                    for (int k = 0; k < NUM_ENTRIES; k++)
                        if (got[k] !== exp_m.m[k]) begin
                            $display("%0t: entry r%0d%0d expected %0d actual %0d", $time,
                                     k / 3, k % 3, $signed(exp_m.m[k]), $signed(got[k]));
                            errors++;
                        end
                    if (degenerate !== exp_m.degen) begin
                        $display("%0t: degenerate expected %0b actual %0b", $time,
                                 exp_m.degen, degenerate);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                matrix_q.push_back(quat_to_matrix(qw, qx, qy, qz, eps_reg));
            if (cfg_we)
                eps_reg = cfg_data;
            pending = matrix_q.size();
        end
    end
endmodule

/* tb/sv/tb_quaternion_to_rotation_matrix.sv */
// testbench top: stimulus for the quaternion to rotation matrix block and the verdict
`timescale 1ns / 1ps
module tb_quaternion_to_rotation_matrix;
    import q2r_pkg::*;

    localparam int unsigned CW = 16;
    localparam int LATENCY = CW + 6;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [CW-1:0] qw = '0, qx = '0, qy = '0, qz = '0;
    logic cfg_we = 1'b0;
    logic [EPS_WIDTH-1:0] cfg_data = '0;
    logic done, degenerate;
    logic signed [CW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    int errors, pending, matrices_seen, degenerate_seen;
    int cycles = 0;

    always #6 clk = ~clk;

    quaternion_to_rotation_matrix #(.COMPONENT_WIDTH(CW)) u_top (.*);

    q2r_checker #(.CW(CW)) u_checker (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_quaternion_to_rotation_matrix: done, errors");
            $finish;
        end
    end

    task automatic send_quat(logic [CW-1:0] w, logic [CW-1:0] x, logic [CW-1:0] y,
                             logic [CW-1:0] z);
        start <= 1'b1;
        qw <= w;
        qx <= x;
        qy <= y;
        qz <= z;
        do @(posedge clk); while (busy);
    endtask

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain_and_write(logic [EPS_WIDTH-1:0] val);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CW-1:0] rand_comp(int mode);
        case (mode)
            0: return CW'($urandom);
            1: return CW'($urandom_range(0, 15) - 8);
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return CW'($urandom_range(0, 300) - 150);
        endcase
    endfunction

    initial
    begin
        logic [EPS_WIDTH-1:0] eps_set[5];
        int burst_mode;
        eps_set = '{16'd0, 16'hffff, 16'd1, 16'd10737, 16'd4000};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: unit axes, extremes, zero, small norms, saturation
        send_quat(16'h7fff, '0, '0, '0);
        send_quat('0, 16'h7fff, '0, '0);
        send_quat('0, '0, 16'h7fff, '0);
        send_quat('0, '0, '0, 16'h7fff);
        send_quat(16'h8000, '0, '0, '0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_quat('0, '0, '0, '0);
        send_quat(16'd1, '0, '0, '0);
        send_quat(16'd103, '0, '0, '0);
        send_quat(16'd104, '0, '0, '0);
        send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_quat(16'd23170, 16'd23170, '0, '0);
        send_quat('0, 16'd23170, 16'd23170, '0);
        send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
        send_quat(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
        for (int ph = 0; ph < 5; ph++)
        begin
            drain_and_write(eps_set[ph]);
            if (ph == 0)
                send_quat('0, '0, '0, '0);
            for (int i = 0; i < 250; i++)
            begin
                burst_mode = $urandom_range(0, 9);
                send_quat(rand_comp(burst_mode % 4), rand_comp($urandom_range(0, 3)),
                          rand_comp(burst_mode % 4), rand_comp($urandom_range(0, 3)));
                if (i % 60 > 40)
                    idle_gap();
            end
        end
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        $display("covered %0d matrices, %0d of them degenerate, over 5 epsilon settings",
                 matrices_seen, degenerate_seen);
        if (errors == 0)
            $display("tb_quaternion_to_rotation_matrix: done, clean");
        else
            $display("tb_quaternion_to_rotation_matrix: done, errors");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/q2r_pkg.sv
rtl/core/q2r_front.sv
rtl/core/q2r_fifo.sv
rtl/core/q2r_divider.sv
rtl/core/q2r_back.sv
rtl/core/quaternion_to_rotation_matrix.sv
tb/sv/q2r_checker.sv
tb/sv/tb_quaternion_to_rotation_matrix.sv
